>>> src/dmbf_pkg.sv
`default_nettype none

package dmbf_pkg;

    // list length limit and position counter
    localparam int MAX_MODES = 256;
    localparam int CNT_W     = $clog2(MAX_MODES + 1);

    // field widths
    localparam int SIZE_W   = 16;
    localparam int RATE_W   = 10;
    localparam int CLK_W    = 32;
    localparam int ID_W     = 32;
    localparam int INDEX_W  = 8;
    localparam int DIST_W   = 30;
    localparam int SUM_W    = 2 * SIZE_W + 1;
    localparam int ERR_W    = 2 * CLK_W;

    // refresh divider
    localparam int DIV_STEPS = CLK_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [DIST_W-1:0] START_BEST = DIST_W'(999999999);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE   = 2'd2;

    typedef struct packed {
        logic              mode_valid;
        logic              interlaced;
        logic [SIZE_W-1:0] mode_width;
        logic [SIZE_W-1:0] mode_height;
        logic [CLK_W-1:0]  dot_clock;
        logic [SIZE_W-1:0] h_total;
        logic [SIZE_W-1:0] v_total;
        logic [ID_W-1:0]   mode_id;
        logic              last_mode;
    } mode_req_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] chosen_index;
        logic [ID_W-1:0]    chosen_id;
        logic [SIZE_W-1:0]  chosen_width;
        logic [SIZE_W-1:0]  chosen_height;
        logic [CLK_W-1:0]   chosen_refresh;
    } mode_result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic prod;
        logic div_step;
        logic diff;
        logic square;
        logic update;
        logic report;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic qualify;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> src/dmbf_if.sv
`default_nettype none

interface dmbf_mode_if import dmbf_pkg::*; ();
    logic      valid;
    logic      ready;
    mode_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dmbf_result_if import dmbf_pkg::*; ();
    logic         valid;
    logic         ready;
    mode_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/dmbf_ctrl.sv
`default_nettype none

module dmbf_ctrl
    import dmbf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PROD   = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_DIFF   = 7'b0001000,
        S_SQUARE = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.qualify ? S_PROD : S_FINISH;
                end
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!status.last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

>>> src/dmbf_datapath.sv
`default_nettype none

module dmbf_datapath
    import dmbf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire mode_req_t             req,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output mode_result_t               res
);

    // configuration
    logic [SIZE_W-1:0] target_width_reg;
    logic [SIZE_W-1:0] target_height_reg;
    logic [RATE_W-1:0] target_rate_reg;

    // captured item
    logic [SIZE_W-1:0]  dx_reg;
    logic [SIZE_W-1:0]  dy_reg;
    logic [CLK_W-1:0]   clk_reg;
    logic [SIZE_W-1:0]  ht_reg;
    logic [SIZE_W-1:0]  vt_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SIZE_W-1:0]  mw_reg;
    logic [SIZE_W-1:0]  mh_reg;
    logic [INDEX_W-1:0] pos_reg;
    logic               last_reg;

    // arithmetic
    logic [2*SIZE_W-1:0] dx_sq_reg;
    logic [2*SIZE_W-1:0] dy_sq_reg;
    logic [CLK_W-1:0]    den_reg;
    logic [CLK_W-1:0]    rem_reg;
    logic [CLK_W-1:0]    quo_reg;
    logic [CLK_W-1:0]    rr_reg;
    logic [SUM_W-1:0]    dist_reg;
    logic [CLK_W-1:0]    diff_reg;
    logic [ERR_W-1:0]    err_reg;

    // search state
    logic [CNT_W-1:0]   count_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [ERR_W-1:0]   best_err_reg;
    logic               best_found_reg;
    logic [INDEX_W-1:0] best_index_reg;
    logic [ID_W-1:0]    best_id_reg;
    logic [SIZE_W-1:0]  best_width_reg;
    logic [SIZE_W-1:0]  best_height_reg;
    logic [CLK_W-1:0]   best_refresh_reg;

    // output stage
    logic         res_valid_reg;
    mode_result_t res_reg;

    logic               in_range;
    logic [CLK_W:0]     shifted;
    logic [CLK_W:0]     trial;
    logic [CLK_W-1:0]   rr_now;
    logic [CLK_W-1:0]   rate_ext;
    logic               rate_on;
    logic               win;

    assign in_range = count_reg < CNT_W'(MAX_MODES);

    assign status.qualify  = in_range && req.mode_valid && !req.interlaced
                             && (req.mode_width <= target_width_reg)
                             && (req.mode_height <= target_height_reg);
    assign status.last     = last_reg;
    assign status.out_free = !res_valid_reg || res_ready;

    // one restoring step per cycle
    assign shifted = {rem_reg, quo_reg[CLK_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    assign rr_now   = (den_reg == '0) ? '0 : quo_reg;
    assign rate_ext = CLK_W'(target_rate_reg);
    assign rate_on  = target_rate_reg != '0;

    assign win = (dist_reg < SUM_W'(best_dist_reg))
                 || ((dist_reg == SUM_W'(best_dist_reg)) && rate_on
                     && (err_reg < best_err_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_width_reg  <= '0;
            target_height_reg <= '0;
            target_rate_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_WIDTH:  target_width_reg  <= cfg_data;
                REG_TARGET_HEIGHT: target_height_reg <= cfg_data;
                REG_TARGET_RATE:   target_rate_reg   <= cfg_data[RATE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dx_reg   <= target_width_reg - req.mode_width;
            dy_reg   <= target_height_reg - req.mode_height;
            clk_reg  <= req.dot_clock;
            ht_reg   <= req.h_total;
            vt_reg   <= req.v_total;
            id_reg   <= req.mode_id;
            mw_reg   <= req.mode_width;
            mh_reg   <= req.mode_height;
            pos_reg  <= INDEX_W'(count_reg);
            last_reg <= req.last_mode;
        end
        if (cmd.prod)
        begin
            dx_sq_reg <= dx_reg * dx_reg;
            dy_sq_reg <= dy_reg * dy_reg;
            den_reg   <= ht_reg * vt_reg;
            rem_reg   <= '0;
            quo_reg   <= clk_reg;
        end
        if (cmd.div_step)
        begin
            if (!trial[CLK_W])
            begin
                rem_reg <= trial[CLK_W-1:0];
                quo_reg <= {quo_reg[CLK_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[CLK_W-1:0];
                quo_reg <= {quo_reg[CLK_W-2:0], 1'b0};
            end
        end
        if (cmd.diff)
        begin
            rr_reg   <= rr_now;
            dist_reg <= SUM_W'(dx_sq_reg) + SUM_W'(dy_sq_reg);
            diff_reg <= (rr_now >= rate_ext) ? rr_now - rate_ext : rate_ext - rr_now;
        end
        if (cmd.square)
        begin
            err_reg <= diff_reg * diff_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            best_dist_reg    <= START_BEST;
            best_err_reg     <= ERR_W'(START_BEST);
            best_found_reg   <= 1'b0;
            best_index_reg   <= '0;
            best_id_reg      <= '0;
            best_width_reg   <= '0;
            best_height_reg  <= '0;
            best_refresh_reg <= '0;
        end
        else if (cmd.report)
        begin
            // start a fresh list
            count_reg        <= '0;
            best_dist_reg    <= START_BEST;
            best_err_reg     <= ERR_W'(START_BEST);
            best_found_reg   <= 1'b0;
            best_index_reg   <= '0;
            best_id_reg      <= '0;
            best_width_reg   <= '0;
            best_height_reg  <= '0;
            best_refresh_reg <= '0;
        end
        else
        begin
            if (cmd.capture && in_range)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.update && win)
            begin
                best_dist_reg    <= dist_reg[DIST_W-1:0];
                best_err_reg     <= rate_on ? err_reg : best_err_reg;
                best_found_reg   <= 1'b1;
                best_index_reg   <= pos_reg;
                best_id_reg      <= id_reg;
                best_width_reg   <= mw_reg;
                best_height_reg  <= mh_reg;
                best_refresh_reg <= rr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.report)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            res_reg.found          <= best_found_reg;
            res_reg.chosen_index   <= best_found_reg ? best_index_reg : '0;
            res_reg.chosen_id      <= best_found_reg ? best_id_reg : '0;
            res_reg.chosen_width   <= best_found_reg ? best_width_reg : '0;
            res_reg.chosen_height  <= best_found_reg ? best_height_reg : '0;
            res_reg.chosen_refresh <= best_found_reg ? best_refresh_reg : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> src/display_mode_best_fit.sv
`default_nettype none

// Best-fit display mode picker. Mode descriptors arrive as requests on the
// modes channel, one per list position, and the request flagged last_mode
// closes the list and yields one request on the result channel: found, plus
// index, id, size and integer refresh of the chosen mode (all zero when no
// mode fit). A mode that passes the screening (valid, progressive, no larger
// than the target, within the first MAX_MODES positions) passes through a
// multiply step for the two 16x16 squares and the h_total*v_total product,
// the restoring divider that forms the refresh one quotient bit per cycle,
// rate difference, rate error square, best-mode compare and list close-out
// before the next mode is accepted; a screened-out mode goes straight to
// close-out. The divider sets the pace. The result sits in an output
// register, so the next list can start while it waits to be taken; only
// a second list end stalls until the first result leaves. Targets are to
// be written through the cfg port while idle; the block does not check it.
module display_mode_best_fit
    import dmbf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    dmbf_mode_if.sink                  modes,
    dmbf_result_if.source              result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: screening, multiply, divide, compare, close-out
    dmbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (modes.valid),
        .in_ready (modes.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, running best and output register
    dmbf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (modes.payload),
        .cmd       (cmd),
        .status    (status),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (result.payload)
    );

endmodule

`default_nettype wire

>>> src/dmbf_checker.sv
`default_nettype none

module dmbf_checker
    import dmbf_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         modes_valid,
    input wire logic         modes_ready,
    input wire logic         result_valid,
    input wire logic         result_ready,
    input wire mode_result_t result_payload
);

    // hold a result until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result request dropped before it was taken");

    // one mode at a time: an accepted request closes the channel next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        modes_valid && modes_ready |=> !modes_ready)
        else $error("mode request taken while previous one still in work");

    // no match reports all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_payload.found |->
            result_payload.chosen_index == '0 && result_payload.chosen_id == '0
            && result_payload.chosen_width == '0 && result_payload.chosen_height == '0
            && result_payload.chosen_refresh == '0)
        else $error("no-match result carries nonzero fields");

    // the result channel comes out of reset quiet
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result channel active as reset releases");

endmodule

bind display_mode_best_fit dmbf_checker u_dmbf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .modes_valid    (modes.valid),
    .modes_ready    (modes.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

`default_nettype wire
